@@ sv/qfs_pkg.sv @@
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared constants and types for the quoted field splitter.
// ----------------------------------------------------------------------------
package qfs_pkg;

  // Byte codes the splitter reacts to
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'd34;

  // Line status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_MANY = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Defaults for the top-level parameters
  localparam int QFS_MAX_FIELDS    = 16;
  localparam int QFS_MAX_FIELD_LEN = 256;

  // One result item
  typedef struct packed {
    logic       keep;
    logic [7:0] data;
    logic [3:0] field_index;
    logic       field_done;
    logic       line_done;
    logic [4:0] field_count;
    logic [1:0] status;
  } qfs_res_t;

endpackage

@@ sv/quoted_field_splitter.sv @@
// ----------------------------------------------------------------------------
// quoted_field_splitter
// Splits a text line, one byte per item, into blank-separated or quoted fields.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while not stalled and gives one result item per
// byte. Each byte goes through an input register, then the parse decision,
// then the result register, from which the result item is presented. The
// parse state (phase, quote flag, field and byte counters, line status) is a
// single register set updated once per byte, so a new byte can be accepted
// every cycle while the output is not stalled. A stalled result holds in the
// result register while the input register still takes one more byte.
module quoted_field_splitter
  import qfs_pkg::*;
#(
  parameter int MAX_FIELDS    = QFS_MAX_FIELDS,
  parameter int MAX_FIELD_LEN = QFS_MAX_FIELD_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_keep,
  output logic [7:0] out_data,
  output logic [3:0] out_field_index,
  output logic       out_field_done,
  output logic       out_line_done,
  output logic [4:0] out_field_count,
  output logic [1:0] out_status
);

  logic       in_vld_r;
  logic [7:0] in_ch_r;
  logic       res_vld_r;
  qfs_res_t   res_r;
  qfs_res_t   res;
  logic       res_adv, step;

  // result register can load when empty or being drained
  assign res_adv  = !res_vld_r || !out_stall;
  assign step     = in_vld_r && res_adv;
  assign in_stall = in_vld_r && !res_adv;

  qfs_parse #(
    .MAX_FIELDS    (MAX_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .ch      (in_ch_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (res_adv)   res_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_ch_r <= in_ch;
    if (step)                  res_r   <= res;
  end

  assign out_valid       = res_vld_r;
  assign out_keep        = res_r.keep;
  assign out_data        = res_r.data;
  assign out_field_index = res_r.field_index;
  assign out_field_done  = res_r.field_done;
  assign out_line_done   = res_r.line_done;
  assign out_field_count = res_r.field_count;
  assign out_status      = res_r.status;

endmodule

@@ sv/qfs_parse.sv @@
// ----------------------------------------------------------------------------
// qfs_parse
// Per-line parse state and the single-byte decision logic. The result for the
// presented byte is combinational; state advances when step_en is high.
// ----------------------------------------------------------------------------
module qfs_parse
  import qfs_pkg::*;
#(
  parameter int MAX_FIELDS    = QFS_MAX_FIELDS,
  parameter int MAX_FIELD_LEN = QFS_MAX_FIELD_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] ch,
  output qfs_res_t   res
);

  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam int CW = $clog2(MAX_FIELD_LEN + 1);

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_FIELD   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  phase_t        phase_r,      phase_nxt;
  logic          in_quote_r,   in_quote_nxt;
  logic [FW-1:0] fields_r,     fields_nxt;
  logic [CW-1:0] chars_r,      chars_nxt;
  logic [1:0]    line_err_r,   line_err_nxt;

  logic term, blank, quote, in_field;

  assign term  = (ch == CH_NUL) || (ch == CH_LF);
  assign blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign quote = (ch == CH_QUOTE);

  always_comb begin
    phase_nxt       = phase_r;
    in_quote_nxt    = in_quote_r;
    fields_nxt      = fields_r;
    chars_nxt       = chars_r;
    line_err_nxt    = line_err_r;
    in_field        = 1'b0;
    res.keep        = 1'b0;
    res.data        = 8'd0;
    res.field_index = 4'(fields_r);
    res.field_done  = 1'b0;
    res.line_done   = 1'b0;

    case (phase_r)
      PH_FIELD: begin
        in_field = 1'b1;
      end
      PH_DISCARD: begin
        if (term) res.line_done = 1'b1;
      end
      default: begin
        if (blank) begin
          // leading blank, dropped
        end else if (quote) begin
          in_quote_nxt = 1'b1;
          chars_nxt    = '0;
          phase_nxt    = PH_FIELD;
        end else if (term) begin
          res.line_done = 1'b1;
        end else begin
          chars_nxt = '0;
          phase_nxt = PH_FIELD;
          in_field  = 1'b1;
        end
      end
    endcase

    if (in_field) begin
      if (chars_nxt >= CW'(MAX_FIELD_LEN)) begin
        line_err_nxt = ST_TOO_LONG;
        if (term) res.line_done = 1'b1;
        else      phase_nxt     = PH_DISCARD;
      end else if (quote || (blank && !in_quote_nxt)) begin
        fields_nxt     = fields_r + 1'b1;
        res.field_done = 1'b1;
        in_quote_nxt   = 1'b0;
        phase_nxt      = PH_SKIP;
        if (fields_nxt >= FW'(MAX_FIELDS)) begin
          line_err_nxt = ST_TOO_MANY;
          phase_nxt    = PH_DISCARD;
        end
      end else if (term) begin
        // line end closes the open field, even an empty quoted one
        fields_nxt     = fields_r + 1'b1;
        res.field_done = 1'b1;
        res.line_done  = 1'b1;
      end else begin
        res.keep  = 1'b1;
        res.data  = ch;
        chars_nxt = chars_nxt + 1'b1;
      end
    end

    res.field_count = 5'(fields_nxt);
    res.status      = line_err_nxt;

    if (res.line_done) begin
      phase_nxt    = PH_SKIP;
      in_quote_nxt = 1'b0;
      fields_nxt   = '0;
      chars_nxt    = '0;
      line_err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      in_quote_r <= 1'b0;
      fields_r   <= '0;
      chars_r    <= '0;
      line_err_r <= ST_OK;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      in_quote_r <= in_quote_nxt;
      fields_r   <= fields_nxt;
      chars_r    <= chars_nxt;
      line_err_r <= line_err_nxt;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quoted_field_splitter.
// ----------------------------------------------------------------------------
// Text lines are queued up front: a few hand-written lines for the corner
// cases, then random lines. Most random lines are well formed, with plain and
// quoted fields, blanks and both line ends. Some lines overflow the field
// count and some are raw noise; two hand-written lines overflow the field
// length. A driver feeds the bytes and a local line parser predicts each
// result item. A monitor compares the results field by field. Both sides idle
// in phases.
// ----------------------------------------------------------------------------
module tb_top;
  import qfs_pkg::*;

  localparam int STIM_ITEMS  = 550;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum logic [1:0] {SCAN_BLANKS, IN_FIELD, DROP_REST} scan_t;
  typedef enum int {NO_IDLE, SEND_IDLE, RECV_IDLE, BOTH_IDLE} idle_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_keep;
  logic [7:0] out_data;
  logic [3:0] out_field_index;
  logic       out_field_done;
  logic       out_line_done;
  logic [4:0] out_field_count;
  logic [1:0] out_status;

  quoted_field_splitter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_keep       (out_keep),
    .out_data       (out_data),
    .out_field_index(out_field_index),
    .out_field_done (out_field_done),
    .out_line_done  (out_line_done),
    .out_field_count(out_field_count),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  logic [7:0] line_bytes[$];
  qfs_res_t   token_q[$];
  int         bytes_total = 0;
  int         bytes_sent = 0;
  int         errors = 0;
  int         quiet = 0;
  idle_mode_t idle_mode;

  // Parser state
  scan_t      scan = SCAN_BLANKS;
  logic       quoted = 1'b0;
  int         fld_cnt = 0;
  int         fld_len = 0;
  logic [1:0] line_err = ST_OK;

  // Run statistics
  int lines_seen = 0, fields_seen = 0, kept_bytes = 0;
  int many_lines = 0, long_lines = 0;

  function automatic qfs_res_t split_byte(logic [7:0] c);
    qfs_res_t r;
    logic     term, blank, quote, open_now;
    r        = '0;
    term     = (c == CH_NUL) || (c == CH_LF);
    blank    = (c == CH_SPACE) || (c == CH_TAB);
    quote    = (c == CH_QUOTE);
    open_now = 1'b0;
    r.field_index = fld_cnt[3:0];
    case (scan)
      IN_FIELD: open_now = 1'b1;
      DROP_REST: if (term) r.line_done = 1'b1;
      default: begin
        if (blank) begin
        end else if (quote) begin
          quoted  = 1'b1;
          fld_len = 0;
          scan    = IN_FIELD;
        end else if (term) begin
          r.line_done = 1'b1;
        end else begin
          fld_len  = 0;
          scan     = IN_FIELD;
          open_now = 1'b1;
        end
      end
    endcase
    if (open_now) begin
      if (fld_len >= QFS_MAX_FIELD_LEN) begin
        line_err = ST_TOO_LONG;
        if (term) r.line_done = 1'b1;
        else scan = DROP_REST;
      end else if (quote || (blank && !quoted)) begin
        fld_cnt++;
        r.field_done = 1'b1;
        quoted = 1'b0;
        scan = SCAN_BLANKS;
        if (fld_cnt >= QFS_MAX_FIELDS) begin
          line_err = ST_TOO_MANY;
          scan = DROP_REST;
        end
      end else if (term) begin
        fld_cnt++;
        r.field_done = 1'b1;
        r.line_done = 1'b1;
      end else begin
        r.keep = 1'b1;
        r.data = c;
        fld_len++;
      end
    end
    r.field_count = fld_cnt[4:0];
    r.status = line_err;
    fields_seen += r.field_done;
    kept_bytes += r.keep;
    if (r.line_done) begin
      lines_seen++;
      if (line_err == ST_TOO_MANY) many_lines++;
      if (line_err == ST_TOO_LONG) long_lines++;
      scan = SCAN_BLANKS;
      quoted = 1'b0;
      fld_cnt = 0;
      fld_len = 0;
      line_err = ST_OK;
    end
    return r;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(33, 126));
    end while (b == CH_LF || b == CH_TAB || b == CH_SPACE || b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 1) == 0) ? CH_LF : CH_NUL;
  endfunction

  task automatic add_long_line(int len);
    repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_byte());
    repeat (len) line_bytes.push_back(word_byte());
    line_bytes.push_back(line_end());
  endtask

  task automatic add_random_line();
    int pick, nf, len;
    bit qf;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
      line_bytes.push_back(line_end());
    end else begin
      nf = (pick < 22) ? $urandom_range(15, 18) : $urandom_range(0, 5);
      for (int f = 0; f < nf; f++) begin
        repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_byte());
        qf = ($urandom_range(0, 2) == 0);
        len = $urandom_range(qf ? 0 : 1, 6);
        if (qf) begin
          line_bytes.push_back(CH_QUOTE);
          repeat (len)
            line_bytes.push_back(($urandom_range(0, 3) == 0) ? blank_byte() : word_byte());
          if (f < nf - 1 || $urandom_range(0, 4) != 0) line_bytes.push_back(CH_QUOTE);
        end else begin
          repeat (len) line_bytes.push_back(word_byte());
          // a quote also closes a plain field
          if (f < nf - 1)
            line_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_QUOTE : blank_byte());
        end
      end
      repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_byte());
      line_bytes.push_back(line_end());
    end
  endtask

  task automatic check_result(qfs_res_t exp);
    if (out_keep !== exp.keep) begin
      $error("keep: expected %0d, got %0d", exp.keep, out_keep);
      errors++;
    end
    if (out_data !== exp.data) begin
      $error("data: expected 0x%02h, got 0x%02h", exp.data, out_data);
      errors++;
    end
    if (out_field_index !== exp.field_index) begin
      $error("field_index: expected %0d, got %0d", exp.field_index, out_field_index);
      errors++;
    end
    if (out_field_done !== exp.field_done) begin
      $error("field_done: expected %0d, got %0d", exp.field_done, out_field_done);
      errors++;
    end
    if (out_line_done !== exp.line_done) begin
      $error("line_done: expected %0d, got %0d", exp.line_done, out_line_done);
      errors++;
    end
    if (out_field_count !== exp.field_count) begin
      $error("field_count: expected %0d, got %0d", exp.field_count, out_field_count);
      errors++;
    end
    if (out_status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, out_status);
      errors++;
    end
  endtask

  // Idle phases follow the share of bytes already sent
  always_comb begin
    if (bytes_total == 0) idle_mode = NO_IDLE;
    else idle_mode = idle_mode_t'((bytes_sent * 4 / bytes_total) > 3 ? 3 :
                                  (bytes_sent * 4 / bytes_total));
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        token_q.push_back(split_byte(in_ch));
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (line_bytes.size() > 0 &&
            !((idle_mode == SEND_IDLE && $urandom_range(0, 99) < 59) ||
              (idle_mode == BOTH_IDLE && $urandom_range(0, 99) < 29))) begin
          in_valid <= 1'b1;
          in_ch <= line_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          check_result(token_q.pop_front());
        end
      end
      out_stall <= (idle_mode == RECV_IDLE && $urandom_range(0, 99) < 59) ||
                   (idle_mode == BOTH_IDLE && $urandom_range(0, 99) < 29);
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("quoted_field_splitter: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    // empty line; blanks then a lone quote closed by the line end
    line_bytes = '{CH_LF, CH_SPACE, CH_TAB, CH_QUOTE, CH_NUL};
    // plain field closed by a quote, quoted field with a blank, plain field
    // closed by the line end
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h80);
    line_bytes.push_back(CH_QUOTE);
    line_bytes.push_back(CH_QUOTE);
    line_bytes.push_back(8'h78);
    line_bytes.push_back(CH_SPACE);
    line_bytes.push_back(8'h79);
    line_bytes.push_back(CH_QUOTE);
    line_bytes.push_back(8'h01);
    line_bytes.push_back(CH_LF);
    // blank closes a field; tab kept inside quotes; discarded-free line end
    line_bytes.push_back(8'h7F);
    line_bytes.push_back(CH_TAB);
    line_bytes.push_back(CH_QUOTE);
    line_bytes.push_back(CH_TAB);
    line_bytes.push_back(8'h41);
    line_bytes.push_back(CH_NUL);
    // one field more than the limit, rest of the line dropped
    repeat (QFS_MAX_FIELDS + 1) begin
      line_bytes.push_back(word_byte());
      line_bytes.push_back(CH_SPACE);
    end
    line_bytes.push_back(line_end());
    // field length right at and just past the limit
    add_long_line(QFS_MAX_FIELD_LEN);
    add_long_line(QFS_MAX_FIELD_LEN + 1);
    while (line_bytes.size() < STIM_ITEMS) add_random_line();
    bytes_total = line_bytes.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < bytes_total || token_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d bytes in %0d lines: %0d fields closed, %0d bytes kept",
             bytes_total, lines_seen, fields_seen, kept_bytes);
    $display("%0d lines hit the field limit, %0d lines hit the length limit",
             many_lines, long_lines);
    if (errors == 0 && token_q.size() == 0) begin
      $display("quoted_field_splitter: match");
    end else begin
      $display("quoted_field_splitter: mismatch");
    end
    $finish;
  end

endmodule
